>>> src/vbi_pkg.sv
// ----------------------------------------------------------------------------
// vbi_pkg: shared types, constants and fixed-point helpers
// Saturating Q16.16 arithmetic and the pipeline geometry of the Verlet step.
// ----------------------------------------------------------------------------
`default_nettype none
package vbi_pkg;

  // Number format.
  localparam int DW = 32;
  localparam int FB = 16;
  // Width of a full quotient before saturation.
  localparam int QW = DW + FB;

  // Divider geometry: quotient bits resolved in each stage.
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = QW / DIV_STEP;

  // Cycles from an accepted start to its result strobe.
  localparam int LATENCY = DIV_STAGES + 9;

  typedef logic signed [DW-1:0] fix_t;
  typedef logic        [DW-2:0] ufix_t;

  // Two pi in Q16.16, rounded to nearest.
  localparam fix_t TWO_PI = 32'sd411775;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_CENTER_X       = 2'd0,
    REG_CENTER_Y       = 2'd1,
    REG_CENTER_GRAVITY = 2'd2,
    REG_TIME_STEP      = 2'd3
  } reg_idx_t;

  localparam fix_t SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam fix_t SMIN = {1'b1, {(DW-1){1'b0}}};

  function automatic fix_t sat_add(fix_t a, fix_t b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? SMIN : SMAX;
    end
    return s[DW-1:0];
  endfunction

  function automatic fix_t sat_sub(fix_t a, fix_t b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? SMIN : SMAX;
    end
    return s[DW-1:0];
  endfunction

  // Signed result from a sign and a magnitude, saturated to the range.
  function automatic fix_t from_mag(logic neg, logic [QW-1:0] q);
    logic [QW-1:0] lim;
    logic [QW-1:0] qs;
    lim = neg ? (QW'(1) << (DW-1)) : ((QW'(1) << (DW-1)) - QW'(1));
    qs  = (q > lim) ? lim : q;
    if (neg) begin
      return fix_t'(~qs[DW-1:0] + DW'(1));
    end
    return fix_t'(qs[DW-1:0]);
  endfunction

  function automatic logic [DW-1:0] mag(fix_t a);
    return a[DW-1] ? (~a + DW'(1)) : a;
  endfunction

  // Product truncated toward zero, then saturated.
  function automatic fix_t fx_mul(fix_t a, fix_t b);
    logic [2*DW-1:0] prod;
    prod = mag(a) * mag(b);
    return from_mag(a[DW-1] ^ b[DW-1], prod[2*DW-1:FB]);
  endfunction

endpackage
`default_nettype wire

>>> src/vbi_lane.sv
// ----------------------------------------------------------------------------
// vbi_lane: one axis of the Verlet step
// Pulls toward a center, damps velocity, divides by mass in a pipelined
// restoring divider and adds the time-step scaled acceleration.
// ----------------------------------------------------------------------------
`default_nettype none
module vbi_lane (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire vbi_pkg::fix_t  p,
  input  wire vbi_pkg::fix_t  pold,
  input  wire vbi_pkg::fix_t  f,
  input  wire vbi_pkg::fix_t  c,
  input  wire vbi_pkg::ufix_t m,
  input  wire vbi_pkg::ufix_t fr,
  input  wire vbi_pkg::ufix_t g,
  input  wire vbi_pkg::ufix_t dt,
  output logic                out_valid,
  output vbi_pkg::fix_t       out_n,
  output vbi_pkg::fix_t       out_p
);
  import vbi_pkg::*;

  // Stage 1: distances, velocity and mass products.
  logic  s1_vld_r;
  fix_t  s1_d_r, s1_v_r, s1_mg_r, s1_mf_r, s1_p_r, s1_f_r;
  ufix_t s1_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_valid;
    end
    s1_d_r  <= sat_sub(c, p);
    s1_v_r  <= sat_sub(p, pold);
    s1_mg_r <= fx_mul(fix_t'({1'b0, m}), fix_t'({1'b0, g}));
    s1_mf_r <= fx_mul(fix_t'({1'b0, m}), fix_t'({1'b0, fr}));
    s1_p_r  <= p;
    s1_f_r  <= f;
    s1_m_r  <= m;
  end

  // Stage 2: gravity force and negated damping factor.
  logic  s2_vld_r;
  fix_t  s2_k1_r, s2_nm_r, s2_v_r, s2_p_r, s2_pv_r, s2_f_r;
  ufix_t s2_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_k1_r <= fx_mul(s1_mg_r, s1_d_r);
    s2_nm_r <= sat_sub('0, s1_mf_r);
    s2_v_r  <= s1_v_r;
    s2_p_r  <= s1_p_r;
    s2_pv_r <= sat_add(s1_p_r, s1_v_r);
    s2_f_r  <= s1_f_r;
    s2_m_r  <= s1_m_r;
  end

  // Stage 3: damping force, first force sum.
  logic  s3_vld_r;
  fix_t  s3_k2_r, s3_f1_r, s3_p_r, s3_pv_r;
  ufix_t s3_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_k2_r <= fx_mul(s2_nm_r, s2_v_r);
    s3_f1_r <= sat_add(s2_f_r, s2_k1_r);
    s3_p_r  <= s2_p_r;
    s3_pv_r <= s2_pv_r;
    s3_m_r  <= s2_m_r;
  end

  // Stage 4: total force, split into sign and dividend for the divider.
  logic          dv_vld_r [DIV_STAGES+1];
  logic [QW-1:0] dv_nq_r  [DIV_STAGES+1];
  ufix_t         dv_rem_r [DIV_STAGES+1];
  ufix_t         dv_m_r   [DIV_STAGES+1];
  logic          dv_neg_r [DIV_STAGES+1];
  logic          dv_mz_r  [DIV_STAGES+1];
  fix_t          dv_p_r   [DIV_STAGES+1];
  fix_t          dv_pv_r  [DIV_STAGES+1];
  fix_t          f2;

  assign f2 = sat_add(s3_f1_r, s3_k2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else begin
      dv_vld_r[0] <= s3_vld_r;
    end
    dv_nq_r[0]  <= {mag(f2), {FB{1'b0}}};
    dv_rem_r[0] <= '0;
    dv_m_r[0]   <= s3_m_r;
    dv_neg_r[0] <= f2[DW-1];
    dv_mz_r[0]  <= (s3_m_r == '0);
    dv_p_r[0]   <= s3_p_r;
    dv_pv_r[0]  <= s3_pv_r;
  end

  // Divider stages: each resolves DIV_STEP quotient bits by restoring steps.
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    ufix_t         rem_nxt;
    logic [QW-1:0] nq_nxt;

    always_comb begin
      logic [DW-1:0] t;
      logic          qb;
      rem_nxt = dv_rem_r[k-1];
      nq_nxt  = dv_nq_r[k-1];
      for (int i = 0; i < DIV_STEP; i++) begin
        t  = {rem_nxt, nq_nxt[QW-1]};
        qb = (t >= {1'b0, dv_m_r[k-1]});
        if (qb) begin
          t = t - {1'b0, dv_m_r[k-1]};
        end
        rem_nxt = t[DW-2:0];
        nq_nxt  = {nq_nxt[QW-2:0], qb};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k] <= 1'b0;
      end else begin
        dv_vld_r[k] <= dv_vld_r[k-1];
      end
      dv_nq_r[k]  <= nq_nxt;
      dv_rem_r[k] <= rem_nxt;
      dv_m_r[k]   <= dv_m_r[k-1];
      dv_neg_r[k] <= dv_neg_r[k-1];
      dv_mz_r[k]  <= dv_mz_r[k-1];
      dv_p_r[k]   <= dv_p_r[k-1];
      dv_pv_r[k]  <= dv_pv_r[k-1];
    end
  end

  // Final stages: acceleration, two time-step products, position sum.
  logic e1_vld_r, e2_vld_r, e3_vld_r, e4_vld_r;
  fix_t e1_a_r, e2_t_r, e3_s_r, e4_n_r;
  fix_t e1_p_r, e2_p_r, e3_p_r, e4_p_r;
  fix_t e1_pv_r, e2_pv_r, e3_pv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_vld_r <= 1'b0;
      e2_vld_r <= 1'b0;
      e3_vld_r <= 1'b0;
      e4_vld_r <= 1'b0;
    end else begin
      e1_vld_r <= dv_vld_r[DIV_STAGES];
      e2_vld_r <= e1_vld_r;
      e3_vld_r <= e2_vld_r;
      e4_vld_r <= e3_vld_r;
    end
    // A body without mass gets no acceleration.
    e1_a_r  <= dv_mz_r[DIV_STAGES] ? '0
             : from_mag(dv_neg_r[DIV_STAGES], dv_nq_r[DIV_STAGES]);
    e1_p_r  <= dv_p_r[DIV_STAGES];
    e1_pv_r <= dv_pv_r[DIV_STAGES];
    e2_t_r  <= fx_mul(e1_a_r, fix_t'({1'b0, dt}));
    e2_p_r  <= e1_p_r;
    e2_pv_r <= e1_pv_r;
    e3_s_r  <= fx_mul(e2_t_r, fix_t'({1'b0, dt}));
    e3_p_r  <= e2_p_r;
    e3_pv_r <= e2_pv_r;
    e4_n_r  <= sat_add(e3_pv_r, e3_s_r);
    e4_p_r  <= e3_p_r;
  end

  assign out_valid = e4_vld_r;
  assign out_n     = e4_n_r;
  assign out_p     = e4_p_r;

endmodule
`default_nettype wire

>>> src/verlet_body_integration.sv
// ----------------------------------------------------------------------------
// verlet_body_integration: position Verlet step for one 2D body
// Three identical lanes (x, y, angle) followed by a one-turn angle wrap.
// ----------------------------------------------------------------------------
// Channel  Handshake            Payload
// in       start / busy         pos, prev_pos, force, mass, friction, angles
// out      out_valid strobe     next_pos, next_prev_pos, next angles
// cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One body is accepted in every cycle; busy is never raised.
// Each result passes through 4 force stages, 24 divider
// stages of 2 quotient bits each, 4 acceleration stages and the wrap stage.
// Synchronous reset clears all valid bits and restores the configuration registers.
// Results cannot be held off, so the pipeline never stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module verlet_body_integration (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire vbi_pkg::fix_t  in_pos_x,
  input  wire vbi_pkg::fix_t  in_pos_y,
  input  wire vbi_pkg::fix_t  in_prev_pos_x,
  input  wire vbi_pkg::fix_t  in_prev_pos_y,
  input  wire vbi_pkg::fix_t  in_force_x,
  input  wire vbi_pkg::fix_t  in_force_y,
  input  wire vbi_pkg::ufix_t in_mass,
  input  wire vbi_pkg::ufix_t in_friction,
  input  wire vbi_pkg::fix_t  in_angle,
  input  wire vbi_pkg::fix_t  in_prev_angle,
  input  wire vbi_pkg::fix_t  in_torque,
  input  wire vbi_pkg::ufix_t in_angular_friction,
  output logic                out_valid,
  output vbi_pkg::fix_t       out_next_pos_x,
  output vbi_pkg::fix_t       out_next_pos_y,
  output vbi_pkg::fix_t       out_next_prev_pos_x,
  output vbi_pkg::fix_t       out_next_prev_pos_y,
  output vbi_pkg::fix_t       out_next_angle,
  output vbi_pkg::fix_t       out_next_prev_angle,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [31:0]    cfg_data
);
  import vbi_pkg::*;

  // Configuration registers.
  fix_t  center_x_r, center_y_r;
  ufix_t gravity_r, time_step_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r  <= '0;
      center_y_r  <= '0;
      gravity_r   <= '0;
      time_step_r <= ufix_t'(1) << FB;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_CENTER_X:       center_x_r  <= fix_t'(cfg_data);
        REG_CENTER_Y:       center_y_r  <= fix_t'(cfg_data);
        REG_CENTER_GRAVITY: gravity_r   <= cfg_data[DW-2:0];
        REG_TIME_STEP:      time_step_r <= cfg_data[DW-2:0];
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = start && !busy;

  // Lanes: the angle lane has no center pull.
  logic vx, vy, va;
  fix_t nx, ny, na, px, py, pa;

  vbi_lane u_lane_x (
    .clk, .rst_n, .in_valid(accept),
    .p(in_pos_x), .pold(in_prev_pos_x), .f(in_force_x), .c(center_x_r),
    .m(in_mass), .fr(in_friction), .g(gravity_r), .dt(time_step_r),
    .out_valid(vx), .out_n(nx), .out_p(px)
  );

  vbi_lane u_lane_y (
    .clk, .rst_n, .in_valid(accept),
    .p(in_pos_y), .pold(in_prev_pos_y), .f(in_force_y), .c(center_y_r),
    .m(in_mass), .fr(in_friction), .g(gravity_r), .dt(time_step_r),
    .out_valid(vy), .out_n(ny), .out_p(py)
  );

  vbi_lane u_lane_a (
    .clk, .rst_n, .in_valid(accept),
    .p(in_angle), .pold(in_prev_angle), .f(in_torque), .c('0),
    .m(in_mass), .fr(in_angular_friction), .g('0), .dt(time_step_r),
    .out_valid(va), .out_n(na), .out_p(pa)
  );

  // Wrap stage: one turn at most, previous angle follows.
  logic out_valid_r;
  fix_t nx_r, ny_r, px_r, py_r, ang_r, pang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vx && vy && va;
    end
    nx_r <= nx;
    ny_r <= ny;
    px_r <= px;
    py_r <= py;
    if (na > TWO_PI) begin
      ang_r  <= sat_sub(na, TWO_PI);
      pang_r <= sat_sub(pa, TWO_PI);
    end else if (na < 0) begin
      ang_r  <= sat_add(na, TWO_PI);
      pang_r <= sat_add(pa, TWO_PI);
    end else begin
      ang_r  <= na;
      pang_r <= pa;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_next_pos_x      = nx_r;
  assign out_next_pos_y      = ny_r;
  assign out_next_prev_pos_x = px_r;
  assign out_next_prev_pos_y = py_r;
  assign out_next_angle      = ang_r;
  assign out_next_prev_angle = pang_r;

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_valid)
    else $error("result strobe missing after start");

  a_lanes_aligned : assert property (@(posedge clk) disable iff (!rst_n)
    (vx == vy) && (vy == va))
    else $error("lane valid bits out of step");

  a_prev_x : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY (out_next_prev_pos_x == $past(in_pos_x, LATENCY)))
    else $error("previous x does not match accepted position");

  a_prev_y : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY (out_next_prev_pos_y == $past(in_pos_y, LATENCY)))
    else $error("previous y does not match accepted position");
`endif

endmodule
`default_nettype wire
